// ===== rtl/tsq_pkg.sv =====
package tsq_pkg;

    // Width of the pressure window registers and of the pressure result
    localparam int PRESS_W = 16;

    // Width of the configuration register index
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PEN_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_JUMP_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_JUMP_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_HIGH = 3'd4;

    // Reset values of the configuration registers
    localparam int PEN_THRESHOLD_RST = 50;
    localparam int X_JUMP_LIMIT_RST  = 500;
    localparam int Y_JUMP_LIMIT_RST  = 400;
    localparam int PRESSURE_LOW_RST  = 1000;
    localparam int PRESSURE_HIGH_RST = 6000;

    // Result item kinds
    localparam logic EVENT_POINT  = 1'b0;
    localparam logic EVENT_PEN_UP = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic qualify;   // pen and jump tests, position update, multiply
        logic div_step;  // one restoring division step
        logic emit;      // load the output registers
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pen_down;
        logic jump;
        logic in_window;
    } status_t;

endpackage

// ===== rtl/tsq_ctrl.sv =====
module tsq_ctrl #(
    parameter int DIV_STEPS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  tsq_pkg::status_t status,
    output tsq_pkg::cmd_t    cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUAL,
        S_DIV,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    // The output register is free when empty or being taken this cycle
    assign slot_free = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Decode commands from the state
    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        cmd.qualify  = (state_reg == S_QUAL);
        cmd.div_step = (state_reg == S_DIV);
        cmd.emit     = (state_reg == S_EMIT) && slot_free;
    end

    // Next state, step count and output valid
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_QUAL;
                end
            end
            S_QUAL:
            begin
                cnt_next = '0;
                if (!status.pen_down)
                begin
                    state_next = S_EMIT;
                end
                else if (status.jump)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = status.in_window ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/tsq_datapath.sv =====
module tsq_datapath #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [SAMPLE_BITS-1:0]        cross_z1,
    input  logic [SAMPLE_BITS-1:0]        cross_z2,
    input  logic [SAMPLE_BITS-1:0]        pos_x,
    input  logic [SAMPLE_BITS-1:0]        pos_y,
    input  logic                          cfg_we,
    input  logic [tsq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsq_pkg::PRESS_W-1:0]   cfg_data,
    input  tsq_pkg::cmd_t                 cmd,
    output tsq_pkg::status_t              status,
    output logic                          event_kind,
    output logic [SAMPLE_BITS-1:0]        point_x,
    output logic [SAMPLE_BITS-1:0]        point_y,
    output logic [tsq_pkg::PRESS_W-1:0]   pressure
);

    localparam int SB = SAMPLE_BITS;
    localparam int QW = 2 * SAMPLE_BITS;
    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
    // A limit above the largest difference never trips; saturate it
    localparam int X_LIM_RST = (tsq_pkg::X_JUMP_LIMIT_RST > SAMPLE_MAX) ?
                               SAMPLE_MAX : tsq_pkg::X_JUMP_LIMIT_RST;
    localparam int Y_LIM_RST = (tsq_pkg::Y_JUMP_LIMIT_RST > SAMPLE_MAX) ?
                               SAMPLE_MAX : tsq_pkg::Y_JUMP_LIMIT_RST;
    localparam int THR_RST   = (tsq_pkg::PEN_THRESHOLD_RST > SAMPLE_MAX) ?
                               SAMPLE_MAX : tsq_pkg::PEN_THRESHOLD_RST;

    // Configuration
    logic [SB-1:0]               pen_threshold_reg;
    logic [SB-1:0]               x_jump_limit_reg;
    logic [SB-1:0]               y_jump_limit_reg;
    logic [tsq_pkg::PRESS_W-1:0] pressure_low_reg;
    logic [tsq_pkg::PRESS_W-1:0] pressure_high_reg;

    // Captured item
    logic [SB-1:0] z1_reg;
    logic [SB-1:0] z2_reg;
    logic [SB-1:0] x_reg;
    logic [SB-1:0] y_reg;

    // Last position
    logic [SB-1:0] last_x_reg;
    logic [SB-1:0] last_y_reg;
    logic          last_x_valid_reg;
    logic          last_y_valid_reg;

    // Divider: dividend shifts out at the top while quotient bits shift in
    logic [QW-1:0] dq_reg;
    logic [SB-1:0] rem_reg;
    logic          pen_up_reg;

    // Output payload
    logic                        event_kind_reg;
    logic [SB-1:0]               point_x_reg;
    logic [SB-1:0]               point_y_reg;
    logic [tsq_pkg::PRESS_W-1:0] pressure_reg;

    logic          pen_down;
    logic [SB-1:0] dx;
    logic [SB-1:0] dy;
    logic          both_valid;
    logic          x_jump;
    logic          y_jump;
    logic [SB:0]   trial;
    logic          q_bit;
    logic [SB-1:0] rem_next;
    logic [QW-1:0] press;
    logic          in_window;

    // Pen and jump tests on the captured item
    assign pen_down   = (z1_reg > pen_threshold_reg) && (z2_reg > z1_reg);
    assign dx         = (x_reg > last_x_reg) ? (x_reg - last_x_reg) : (last_x_reg - x_reg);
    assign dy         = (y_reg > last_y_reg) ? (y_reg - last_y_reg) : (last_y_reg - y_reg);
    assign both_valid = last_x_valid_reg && last_y_valid_reg;
    assign x_jump     = both_valid && (dx > x_jump_limit_reg);
    assign y_jump     = both_valid && !x_jump && (dy > y_jump_limit_reg);

    // One restoring division step
    assign trial    = {rem_reg, dq_reg[QW-1]};
    assign q_bit    = (trial >= {1'b0, z1_reg});
    assign rem_next = q_bit ? SB'(trial - {1'b0, z1_reg}) : trial[SB-1:0];

    // Pressure window on the finished quotient
    assign press     = dq_reg - QW'(x_reg);
    assign in_window = (press > QW'(pressure_low_reg)) && (press < QW'(pressure_high_reg));

    assign status.pen_down  = pen_down;
    assign status.jump      = x_jump || y_jump;
    assign status.in_window = in_window;

    assign event_kind = event_kind_reg;
    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign pressure   = pressure_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_threshold_reg <= SB'(THR_RST);
            x_jump_limit_reg  <= SB'(X_LIM_RST);
            y_jump_limit_reg  <= SB'(Y_LIM_RST);
            pressure_low_reg  <= tsq_pkg::PRESS_W'(tsq_pkg::PRESSURE_LOW_RST);
            pressure_high_reg <= tsq_pkg::PRESS_W'(tsq_pkg::PRESSURE_HIGH_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsq_pkg::REG_PEN_THRESHOLD: pen_threshold_reg <= cfg_data[SB-1:0];
                tsq_pkg::REG_X_JUMP_LIMIT:  x_jump_limit_reg  <= cfg_data[SB-1:0];
                tsq_pkg::REG_Y_JUMP_LIMIT:  y_jump_limit_reg  <= cfg_data[SB-1:0];
                tsq_pkg::REG_PRESSURE_LOW:  pressure_low_reg  <= cfg_data;
                tsq_pkg::REG_PRESSURE_HIGH: pressure_high_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Last position tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg       <= '0;
            last_y_reg       <= '0;
            last_x_valid_reg <= 1'b0;
            last_y_valid_reg <= 1'b0;
        end
        else if (cmd.qualify)
        begin
            if (!pen_down)
            begin
                last_x_valid_reg <= 1'b0;
                last_y_valid_reg <= 1'b0;
            end
            else if (x_jump)
            begin
                last_x_valid_reg <= 1'b0;
            end
            else if (y_jump)
            begin
                last_y_valid_reg <= 1'b0;
            end
            else
            begin
                last_x_reg       <= x_reg;
                last_y_reg       <= y_reg;
                last_x_valid_reg <= 1'b1;
                last_y_valid_reg <= 1'b1;
            end
        end
    end

    // Capture the item, multiply, then divide one bit a cycle, and load the output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            z1_reg <= cross_z1;
            z2_reg <= cross_z2;
            x_reg  <= pos_x;
            y_reg  <= pos_y;
        end
        if (cmd.qualify)
        begin
            pen_up_reg <= !pen_down;
            dq_reg     <= x_reg * z2_reg;
            rem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[QW-2:0], q_bit};
            rem_reg <= rem_next;
        end
        if (cmd.emit)
        begin
            if (pen_up_reg)
            begin
                event_kind_reg <= tsq_pkg::EVENT_PEN_UP;
                point_x_reg    <= '0;
                point_y_reg    <= '0;
                pressure_reg   <= '0;
            end
            else
            begin
                event_kind_reg <= tsq_pkg::EVENT_POINT;
                point_x_reg    <= x_reg;
                point_y_reg    <= y_reg;
                pressure_reg   <= press[tsq_pkg::PRESS_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/touch_sample_qualifier_top.sv =====
// A touch point passes the qualify state, the divider steps, the window check and the emit state
// after its item is taken; a pen-up event goes from qualify to emit, and a dropped sample frees
// the input from qualify. One item at a time: the restoring divider resolves one quotient bit per
// cycle; emit waits for a free output slot, and the next item may start while a result waits.
// Reset (rst_n, asynchronous, active low): configuration to its defaults, last position
// cleared and invalid, no result pending.
module touch_sample_qualifier_top #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [SAMPLE_BITS-1:0]        cross_z1,
    input  logic [SAMPLE_BITS-1:0]        cross_z2,
    input  logic [SAMPLE_BITS-1:0]        pos_x,
    input  logic [SAMPLE_BITS-1:0]        pos_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          event_kind,
    output logic [SAMPLE_BITS-1:0]        point_x,
    output logic [SAMPLE_BITS-1:0]        point_y,
    output logic [tsq_pkg::PRESS_W-1:0]   pressure,
    input  logic                          cfg_we,
    input  logic [tsq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsq_pkg::PRESS_W-1:0]   cfg_data
);

    tsq_pkg::cmd_t    cmd;
    tsq_pkg::status_t status;

    // Sequence one item at a time
    tsq_ctrl #(
        .DIV_STEPS (2 * SAMPLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Tests, position store, multiply, divide and output registers
    tsq_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cross_z1   (cross_z1),
        .cross_z2   (cross_z2),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .event_kind (event_kind),
        .point_x    (point_x),
        .point_y    (point_y),
        .pressure   (pressure)
    );

    // A pen-up item carries no position or pressure
    a_pen_up_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == tsq_pkg::EVENT_PEN_UP)
        |-> (point_x == '0 && point_y == '0 && pressure == '0))
        else $error("pen-up item with nonzero fields");

    // A touch point lies strictly inside the pressure window
    a_point_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == tsq_pkg::EVENT_POINT)
        |-> (pressure > u_datapath.pressure_low_reg && pressure < u_datapath.pressure_high_reg))
        else $error("touch point outside pressure window");

    // One item at a time: no new item right after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after accepting an item");

    // The output registers load only into a free slot
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || out_ready))
        else $error("output overwritten before it was taken");

endmodule

// ===== bench/touch_sample_qualifier_top_test.sv =====
module touch_sample_qualifier_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = 12;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int PRESS_MAX = (1 << tsq_pkg::PRESS_W) - 1;
    // Leave margin for the divider
    localparam int SETTLE_CYCLES = 2 * SAMPLE_W + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PERCENT = 13;
    localparam int REPORT_LINES = 100;

    typedef struct {
        logic                         kind;
        logic [SAMPLE_W-1:0]          x;
        logic [SAMPLE_W-1:0]          y;
        logic [tsq_pkg::PRESS_W-1:0]  press;
    } touch_event_t;

    // Tracks pen state and qualifier settings, and holds the events still due
    class touch_tracker_t;
        logic [SAMPLE_W-1:0]         thr;
        logic [SAMPLE_W-1:0]         xlim;
        logic [SAMPLE_W-1:0]         ylim;
        logic [tsq_pkg::PRESS_W-1:0] plow;
        logic [tsq_pkg::PRESS_W-1:0] phigh;
        logic [SAMPLE_W-1:0]         last_x;
        logic [SAMPLE_W-1:0]         last_y;
        bit                          x_ok;
        bit                          y_ok;
        touch_event_t                events_due[$];
        int                          errors;
        int                          points;
        int                          pen_ups;
        int                          drops;
        int                          outside;

        function new();
            thr = SAMPLE_W'(tsq_pkg::PEN_THRESHOLD_RST);
            xlim = SAMPLE_W'(tsq_pkg::X_JUMP_LIMIT_RST);
            ylim = SAMPLE_W'(tsq_pkg::Y_JUMP_LIMIT_RST);
            plow = tsq_pkg::PRESS_W'(tsq_pkg::PRESSURE_LOW_RST);
            phigh = tsq_pkg::PRESS_W'(tsq_pkg::PRESSURE_HIGH_RST);
            last_x = '0;
            last_y = '0;
            x_ok = 0;
            y_ok = 0;
            errors = 0;
            points = 0;
            pen_ups = 0;
            drops = 0;
            outside = 0;
        endfunction

        function void write_reg(logic [tsq_pkg::CFG_IDX_W-1:0] idx,
                                logic [tsq_pkg::PRESS_W-1:0] data);
            case (idx)
                tsq_pkg::REG_PEN_THRESHOLD: thr = data[SAMPLE_W-1:0];
                tsq_pkg::REG_X_JUMP_LIMIT:  xlim = data[SAMPLE_W-1:0];
                tsq_pkg::REG_Y_JUMP_LIMIT:  ylim = data[SAMPLE_W-1:0];
                tsq_pkg::REG_PRESSURE_LOW:  plow = data;
                tsq_pkg::REG_PRESSURE_HIGH: phigh = data;
                default: ;
            endcase
        endfunction

        function int axis_gap(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
            return (a > b) ? int'(a - b) : int'(b - a);
        endfunction

        // Qualify one accepted sample and queue the event it causes, if any
        function void note_sample(logic [SAMPLE_W-1:0] z1, logic [SAMPLE_W-1:0] z2,
                                  logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y);
            touch_event_t     ev;
            longint unsigned  press;
            if (!(z1 > thr && z2 > z1))
            begin
                x_ok = 0;
                y_ok = 0;
                ev.kind = tsq_pkg::EVENT_PEN_UP;
                ev.x = '0;
                ev.y = '0;
                ev.press = '0;
                events_due.push_back(ev);
                pen_ups++;
                return;
            end
            // drop a jump, invalidating only the axis that jumped, x first
            if (x_ok && y_ok)
            begin
                if (axis_gap(x, last_x) > int'(xlim))
                begin
                    x_ok = 0;
                    drops++;
                    return;
                end
                if (axis_gap(y, last_y) > int'(ylim))
                begin
                    y_ok = 0;
                    drops++;
                    return;
                end
            end
            last_x = x;
            last_y = y;
            x_ok = 1;
            y_ok = 1;
            // full-width pressure before the window test
            press = (64'(x) * 64'(z2)) / 64'(z1) - 64'(x);
            if (press > 64'(plow) && press < 64'(phigh))
            begin
                ev.kind = tsq_pkg::EVENT_POINT;
                ev.x = x;
                ev.y = y;
                ev.press = press[tsq_pkg::PRESS_W-1:0];
                events_due.push_back(ev);
                points++;
            end
            else
            begin
                outside++;
            end
        endfunction

        task report(string what, longint want, longint got);
            if (errors < REPORT_LINES)
                $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
            errors++;
        endtask

        // Compare one result item with the oldest event due
        task check_event(logic kind, logic [SAMPLE_W-1:0] px, logic [SAMPLE_W-1:0] py,
                         logic [tsq_pkg::PRESS_W-1:0] pr);
            touch_event_t want;
            if (events_due.size() == 0)
            begin
                report("result with no event due, event_kind", longint'(-1), longint'(kind));
                return;
            end
            want = events_due.pop_front();
            if (kind !== want.kind)
                report("event_kind", longint'(want.kind), longint'(kind));
            if (px !== want.x)
                report("point_x", longint'(want.x), longint'(px));
            if (py !== want.y)
                report("point_y", longint'(want.y), longint'(py));
            if (pr !== want.press)
                report("pressure", longint'(want.press), longint'(pr));
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [SAMPLE_W-1:0]           cross_z1;
    logic [SAMPLE_W-1:0]           cross_z2;
    logic [SAMPLE_W-1:0]           pos_x;
    logic [SAMPLE_W-1:0]           pos_y;
    logic                          out_valid;
    logic                          out_ready;
    logic                          event_kind;
    logic [SAMPLE_W-1:0]           point_x;
    logic [SAMPLE_W-1:0]           point_y;
    logic [tsq_pkg::PRESS_W-1:0]   pressure;
    logic                          cfg_we;
    logic [tsq_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tsq_pkg::PRESS_W-1:0]   cfg_data;

    touch_tracker_t tracker = new();
    bit             steady = 0;
    int             samples_sent = 0;
    int             settings_used = 0;
    int             quiet_cycles = 0;

    touch_sample_qualifier_top #(
        .SAMPLE_BITS (SAMPLE_W)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cross_z1   (cross_z1),
        .cross_z2   (cross_z2),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .point_x    (point_x),
        .point_y    (point_y),
        .pressure   (pressure),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // Stall the result side at random, never during the steady stretch
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            out_ready = steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Check results, predict accepted samples, and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                tracker.check_event(event_kind, point_x, point_y, pressure);
                quiet_cycles = 0;
            end
            if (in_valid && in_ready)
            begin
                tracker.note_sample(cross_z1, cross_z2, pos_x, pos_y);
                quiet_cycles = 0;
            end
            if (cfg_we)
                quiet_cycles = 0;
            if (!(out_valid && out_ready) && !(in_valid && in_ready) && !cfg_we)
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: nothing moved for %0d cycles, %0d events due",
                             quiet_cycles, tracker.events_due.size());
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // Offer one sample, idling first at random, and hold it until taken
    task automatic send_sample(int z1, int z2, int x, int y);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        cross_z1 = z1[SAMPLE_W-1:0];
        cross_z2 = z2[SAMPLE_W-1:0];
        pos_x = x[SAMPLE_W-1:0];
        pos_y = y[SAMPLE_W-1:0];
        do @(posedge clk); while (!in_ready);
        samples_sent++;
    endtask

    // Hold the sender until every event due has come and the divider is quiet
    task automatic drain();
        @(negedge clk);
        in_valid = 0;
        while (tracker.events_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [tsq_pkg::CFG_IDX_W-1:0] idx,
                             logic [tsq_pkg::PRESS_W-1:0] data);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        tracker.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 0;
    endtask

    // Load a full setting; the unused upper bits of the 12-bit registers carry junk
    task automatic apply_settings(int thr, int xlim, int ylim, int plow, int phigh);
        drain();
        cfg_write(tsq_pkg::REG_PEN_THRESHOLD, {4'($urandom_range(0, 15)), 12'(thr)});
        cfg_write(tsq_pkg::REG_X_JUMP_LIMIT, {4'($urandom_range(0, 15)), 12'(xlim)});
        cfg_write(tsq_pkg::REG_Y_JUMP_LIMIT, {4'($urandom_range(0, 15)), 12'(ylim)});
        cfg_write(tsq_pkg::REG_PRESSURE_LOW, 16'(plow));
        cfg_write(tsq_pkg::REG_PRESSURE_HIGH, 16'(phigh));
        settings_used++;
    endtask

    // Pick pen-down plate readings aiming at a pressure, mostly inside the window
    function automatic void pick_plates(int x, output int z1, output int z2);
        int thr;
        int span;
        int lo;
        int hi;
        int p;
        int d;
        thr = int'(tracker.thr);
        span = SAMPLE_MAX - 2 - thr;
        if (span > 1500)
            span = 1500;
        z1 = thr + 1 + int'($urandom_range(0, span));
        lo = int'(tracker.plow);
        hi = int'(tracker.phigh);
        if (hi - lo >= 2 && $urandom_range(0, 99) < 75)
            p = int'($urandom_range(hi - 1, lo + 1));
        else
            p = int'($urandom_range(0, PRESS_MAX));
        if (x == 0)
            d = 1;
        else
            d = (p * z1 + x - 1) / x;
        if (d < 1)
            d = 1;
        if (z1 + d > SAMPLE_MAX)
            d = int'($urandom_range(1, SAMPLE_MAX - z1));
        z2 = z1 + d;
    endfunction

    // Move one axis: mostly within its jump limit, sometimes right at or past it
    function automatic int step_axis(int pos, int lim);
        int r;
        int sgn;
        int d;
        r = int'($urandom_range(0, 99));
        sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
        if (r < 5)
            d = sgn * lim;
        else if (r < 10)
            d = sgn * (lim + 1);
        else if (r < 90)
            d = int'($urandom_range(0, 2 * lim)) - lim;
        else
            d = sgn * (lim + 1 + int'($urandom_range(0, 600)));
        pos += d;
        if (pos < 0)
            pos = 0;
        if (pos > SAMPLE_MAX)
            pos = SAMPLE_MAX;
        return pos;
    endfunction

    // One pen stroke: pen-down samples drifting around, usually closed by a lift
    task automatic run_stroke();
        int len;
        int x;
        int y;
        int z1;
        int z2;
        len = int'($urandom_range(1, 24));
        x = int'($urandom_range(0, SAMPLE_MAX));
        y = int'($urandom_range(0, SAMPLE_MAX));
        repeat (len)
        begin
            pick_plates(x, z1, z2);
            send_sample(z1, z2, x, y);
            x = step_axis(x, int'(tracker.xlim));
            y = step_axis(y, int'(tracker.ylim));
        end
        if ($urandom_range(0, 99) < 75)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                z1 = int'($urandom_range(0, tracker.thr));
                z2 = int'($urandom_range(0, SAMPLE_MAX));
            end
            else
            begin
                z1 = int'($urandom_range(0, SAMPLE_MAX));
                z2 = int'($urandom_range(0, z1));
            end
            send_sample(z1, z2, int'($urandom_range(0, SAMPLE_MAX)),
                        int'($urandom_range(0, SAMPLE_MAX)));
        end
    endtask

    // Mostly strokes, the rest unshaped samples
    task automatic run_phase(int count);
        int target;
        target = samples_sent + count;
        while (samples_sent < target)
        begin
            if (int'(tracker.thr) > SAMPLE_MAX - 2 || $urandom_range(0, 99) < 15)
                send_sample(int'($urandom_range(0, SAMPLE_MAX)),
                            int'($urandom_range(0, SAMPLE_MAX)),
                            int'($urandom_range(0, SAMPLE_MAX)),
                            int'($urandom_range(0, SAMPLE_MAX)));
            else
                run_stroke();
        end
    endtask

    initial
    begin
        int idx;
        int plow;
        int phigh;
        rst_n = 0;
        in_valid = 0;
        cross_z1 = '0;
        cross_z2 = '0;
        pos_x = '0;
        pos_y = '0;
        cfg_we = 0;
        cfg_index = tsq_pkg::REG_PEN_THRESHOLD;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // writes to unused indexes must leave the reset settings alone
        for (idx = int'(tsq_pkg::REG_PRESSURE_HIGH) + 1; idx < (1 << tsq_pkg::CFG_IDX_W);
             idx++)
            cfg_write(idx[tsq_pkg::CFG_IDX_W-1:0], 16'($urandom_range(0, PRESS_MAX)));

        // pen-up cases: all zero, z1 at threshold, z2 equal to z1, all ones
        send_sample(0, 0, 0, 0);
        send_sample(50, 100, 10, 10);
        send_sample(51, 51, 10, 10);
        send_sample(4095, 4095, 4095, 4095);
        // first point, then an x jump and a y jump, each followed by recovery with one axis invalid
        send_sample(1000, 2000, 2000, 2000);
        send_sample(1000, 2000, 2501, 2000);
        send_sample(1000, 2000, 4000, 4000);
        send_sample(1000, 2000, 4000, 3599);
        send_sample(1000, 2000, 3500, 4000);
        // steps exactly at both jump limits are accepted
        send_sample(1000, 2000, 4000, 3600);
        send_sample(1000, 2000, 4095, 3600);
        send_sample(0, 4095, 0, 0);
        // pressure at and next to the window edges
        send_sample(1000, 2000, 1000, 1000);
        send_sample(1000, 2000, 1001, 1000);
        send_sample(0, 0, 0, 0);
        send_sample(1000, 4000, 2000, 1000);
        send_sample(0, 0, 0, 0);
        send_sample(51, 149, 3122, 0);
        // pressure far beyond 16 bits, then a zero x
        send_sample(0, 0, 0, 0);
        send_sample(51, 4095, 4095, 4095);
        send_sample(4094, 4095, 0, 4095);
        settings_used++;

        // extremes: zero limits with the widest window, no pen-down possible,
        // and the highest threshold that still lets the pen down
        apply_settings(0, 0, 0, 0, PRESS_MAX);
        run_phase(230);
        apply_settings(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, PRESS_MAX, 0);
        run_phase(60);
        apply_settings(SAMPLE_MAX - 2, SAMPLE_MAX, SAMPLE_MAX, 0, PRESS_MAX);
        run_phase(120);

        // random settings, one of them run without any idling
        for (idx = 0; idx < 4; idx++)
        begin
            plow = int'($urandom_range(0, 8000));
            phigh = plow + int'($urandom_range(0, 20000));
            if (phigh > PRESS_MAX)
                phigh = PRESS_MAX;
            apply_settings(int'($urandom_range(0, 600)), int'($urandom_range(0, 800)),
                           int'($urandom_range(0, 800)), plow, phigh);
            steady = (idx == 1);
            run_phase(260);
        end
        steady = 0;

        apply_settings(tsq_pkg::PEN_THRESHOLD_RST, tsq_pkg::X_JUMP_LIMIT_RST,
                       tsq_pkg::Y_JUMP_LIMIT_RST, tsq_pkg::PRESSURE_LOW_RST,
                       tsq_pkg::PRESSURE_HIGH_RST);
        run_phase(240);

        drain();
        $display("ran %0d samples over %0d register settings: %0d points, %0d pen-up events",
                 samples_sent, settings_used, tracker.points, tracker.pen_ups);
        $display("%0d samples dropped on a jump, %0d outside the pressure window, %0d mismatches",
                 tracker.drops, tracker.outside, tracker.errors);
        if (tracker.errors == 0 && tracker.events_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
